>>> hw/rtl/length_prefixed_packet_deframer_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms, clocked on aclk, idle during reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define LPPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("deframer check failed");

// next-cycle implication
`define LPPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("deframer check failed");

`endif

>>> hw/rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Command codes, event codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT      = 2'd2;

    // register reset values
    localparam logic signed [31:0] RST_ALLOWED_VERSION = 32'sd1;
    localparam logic signed [31:0] RST_MAX_WIDTH       = 32'sd1024;
    localparam logic signed [31:0] RST_MAX_HEIGHT      = 32'sd1024;

    // packet id values
    localparam logic [31:0] ID_HANDSHAKE = 32'd0;
    localparam logic [31:0] ID_TEXT      = 32'd1;
    localparam logic [31:0] ID_RESIZE    = 32'd2;

    // commands from the front parser to the back end
    typedef enum logic [3:0] {
        OP_TEXT,
        OP_EMPTY,
        OP_NEG_LEN,
        OP_UNKNOWN,
        OP_HS_VER,
        OP_HS_W,
        OP_HS_H,
        OP_RS_W,
        OP_RS_H
    } op_t;

    // result event codes
    typedef enum logic [3:0] {
        EV_HS_OK   = 4'd0,
        EV_HS_VER  = 4'd1,
        EV_HS_BIG  = 4'd2,
        EV_TEXT    = 4'd3,
        EV_EMPTY   = 4'd4,
        EV_RS_OK   = 4'd5,
        EV_RS_BIG  = 4'd6,
        EV_UNKNOWN = 4'd7,
        EV_NEG_LEN = 4'd8
    } event_t;

    typedef struct packed {
        op_t         op;
        logic        last;
        logic [31:0] data;
    } cmd_t;

endpackage

>>> hw/rtl/lppd_front.sv
// ----------------------------------------------------------------------------
// Deframer front parser
// Takes stream bytes, builds big-endian words, tracks the packet phase and
// turns each meaningful byte or word into a command for the back end.
// ----------------------------------------------------------------------------
module lppd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           q_full,
    output logic           cmd_valid,
    output lppd_pkg::cmd_t cmd
);
    import lppd_pkg::*;

    typedef enum logic [2:0] {
        PH_ID,
        PH_HS_VER,
        PH_HS_W,
        PH_HS_H,
        PH_TXT_LEN,
        PH_TXT,
        PH_RS_W,
        PH_RS_H
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic [30:0] rem_reg, rem_next;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // byte parsing
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        rem_next   = rem_reg;
        cmd_valid  = 1'b0;
        cmd        = '{op: OP_UNKNOWN, last: 1'b0, data: 32'd0};
        if (accept) begin
            if (phase_reg == PH_TXT) begin
                rem_next  = rem_reg - 31'd1;
                cmd_valid = 1'b1;
                cmd.op    = OP_TEXT;
                cmd.data  = {24'd0, s_in_byte};
                cmd.last  = (rem_next == 31'd0);
                if (rem_next == 31'd0) begin
                    phase_next = PH_ID;
                end
            end else begin
                word_next = {word_reg[23:0], s_in_byte};
                cnt_next  = cnt_reg + 2'd1;
                cmd.data  = word_next;
                if (cnt_reg == 2'd3) begin
                    case (phase_reg)
                        PH_ID: begin
                            if (word_next == ID_HANDSHAKE) begin
                                phase_next = PH_HS_VER;
                            end else if (word_next == ID_TEXT) begin
                                phase_next = PH_TXT_LEN;
                            end else if (word_next == ID_RESIZE) begin
                                phase_next = PH_RS_W;
                            end else begin
                                cmd_valid = 1'b1;
                                cmd.op    = OP_UNKNOWN;
                            end
                        end
                        PH_HS_VER: begin
                            cmd_valid  = 1'b1;
                            cmd.op     = OP_HS_VER;
                            phase_next = PH_HS_W;
                        end
                        PH_HS_W: begin
                            cmd_valid  = 1'b1;
                            cmd.op     = OP_HS_W;
                            phase_next = PH_HS_H;
                        end
                        PH_HS_H: begin
                            cmd_valid  = 1'b1;
                            cmd.op     = OP_HS_H;
                            phase_next = PH_ID;
                        end
                        PH_TXT_LEN: begin
                            if (word_next[31]) begin
                                cmd_valid  = 1'b1;
                                cmd.op     = OP_NEG_LEN;
                                phase_next = PH_ID;
                            end else if (word_next == 32'd0) begin
                                cmd_valid  = 1'b1;
                                cmd.op     = OP_EMPTY;
                                phase_next = PH_ID;
                            end else begin
                                rem_next   = word_next[30:0];
                                phase_next = PH_TXT;
                            end
                        end
                        PH_RS_W: begin
                            cmd_valid  = 1'b1;
                            cmd.op     = OP_RS_W;
                            phase_next = PH_RS_H;
                        end
                        PH_RS_H: begin
                            cmd_valid  = 1'b1;
                            cmd.op     = OP_RS_H;
                            phase_next = PH_ID;
                        end
                        default: begin
                            phase_next = PH_ID;
                        end
                    endcase
                end
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ID;
            cnt_reg   <= 2'd0;
            word_reg  <= 32'd0;
            rem_reg   <= 31'd0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

>>> hw/rtl/lppd_queue.sv
// ----------------------------------------------------------------------------
// Deframer command queue
// Short FIFO between the front parser and the back end.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_deframer_assert.svh"

module lppd_queue #(
    parameter int unsigned Depth = lppd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lppd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lppd_pkg::cmd_t head_cmd
);
    import lppd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    cmd_t            entries_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full       = (cnt_reg == CntW'(Depth));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `LPPD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CntW'(Depth))
    `LPPD_ASSERT_NEXT(a_cnt_grow, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `LPPD_ASSERT_NEXT(a_cnt_drain, do_pop && !do_push, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

>>> hw/rtl/lppd_back.sv
// ----------------------------------------------------------------------------
// Deframer back end
// Holds configuration and terminal state, executes queued commands and
// drives the registered result beat.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_deframer_assert.svh"

module lppd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           head_valid,
    input  lppd_pkg::cmd_t                 head_cmd,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_event_res,
    output logic [7:0]                     m_text_byte,
    output logic                           m_text_last,
    output logic signed [31:0]             m_cur_width,
    output logic signed [31:0]             m_cur_height,
    output logic                           m_shook_hands
);
    import lppd_pkg::*;

    logic signed [31:0] ver_cfg_reg, maxw_cfg_reg, maxh_cfg_reg;
    logic [31:0]        pend_ver_reg, pend_ver_next;
    logic signed [31:0] pend_w_reg, pend_w_next;
    logic signed [31:0] stored_w_reg, stored_w_next;
    logic signed [31:0] stored_h_reg, stored_h_next;
    logic               shook_reg, shook_next;
    logic               out_valid_reg, out_valid_next;
    event_t             event_reg, event_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic signed [31:0] word_s;
    logic               over;

    assign cfg_ready = 1'b1;
    assign word_s    = signed'(head_cmd.data);
    assign over      = (pend_w_reg > maxw_cfg_reg) || (word_s > maxh_cfg_reg);
    assign pop       = head_valid && (!out_valid_reg || m_ready);

    // command execution
    always_comb begin
        pend_ver_next  = pend_ver_reg;
        pend_w_next    = pend_w_reg;
        stored_w_next  = stored_w_reg;
        stored_h_next  = stored_h_reg;
        shook_next     = shook_reg;
        out_valid_next = out_valid_reg && !m_ready;
        event_next     = event_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (pop) begin
            byte_next = 8'd0;
            last_next = 1'b0;
            case (head_cmd.op)
                OP_HS_VER: begin
                    pend_ver_next = head_cmd.data;
                end
                OP_HS_W, OP_RS_W: begin
                    pend_w_next = word_s;
                end
                OP_HS_H: begin
                    out_valid_next = 1'b1;
                    if (pend_ver_reg != unsigned'(ver_cfg_reg)) begin
                        event_next = EV_HS_VER;
                    end else if (over) begin
                        event_next = EV_HS_BIG;
                    end else begin
                        event_next    = EV_HS_OK;
                        shook_next    = 1'b1;
                        stored_w_next = pend_w_reg;
                        stored_h_next = word_s;
                    end
                end
                OP_RS_H: begin
                    out_valid_next = 1'b1;
                    stored_w_next  = pend_w_reg;
                    stored_h_next  = word_s;
                    event_next     = over ? EV_RS_BIG : EV_RS_OK;
                end
                OP_TEXT: begin
                    out_valid_next = 1'b1;
                    event_next     = EV_TEXT;
                    byte_next      = head_cmd.data[7:0];
                    last_next      = head_cmd.last;
                end
                OP_EMPTY: begin
                    out_valid_next = 1'b1;
                    event_next     = EV_EMPTY;
                end
                OP_NEG_LEN: begin
                    out_valid_next = 1'b1;
                    event_next     = EV_NEG_LEN;
                end
                default: begin
                    out_valid_next = 1'b1;
                    event_next     = EV_UNKNOWN;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_cfg_reg  <= RST_ALLOWED_VERSION;
            maxw_cfg_reg <= RST_MAX_WIDTH;
            maxh_cfg_reg <= RST_MAX_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ALLOWED_VERSION: ver_cfg_reg  <= signed'(cfg_data);
                REG_MAX_WIDTH:       maxw_cfg_reg <= signed'(cfg_data);
                REG_MAX_HEIGHT:      maxh_cfg_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // terminal state and result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_ver_reg  <= 32'd0;
            pend_w_reg    <= 32'sd0;
            stored_w_reg  <= 32'sd0;
            stored_h_reg  <= 32'sd0;
            shook_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_HS_OK;
            byte_reg      <= 8'd0;
            last_reg      <= 1'b0;
        end else begin
            pend_ver_reg  <= pend_ver_next;
            pend_w_reg    <= pend_w_next;
            stored_w_reg  <= stored_w_next;
            stored_h_reg  <= stored_h_next;
            shook_reg     <= shook_next;
            out_valid_reg <= out_valid_next;
            event_reg     <= event_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_res   = event_reg;
    assign m_text_byte   = byte_reg;
    assign m_text_last   = last_reg;
    assign m_cur_width   = stored_w_reg;
    assign m_cur_height  = stored_h_reg;
    assign m_shook_hands = shook_reg;

    `LPPD_ASSERT_NOW(a_text_fields, out_valid_reg && (event_reg != EV_TEXT), (byte_reg == 8'd0) && !last_reg)
    `LPPD_ASSERT_NEXT(a_shook_sticky, shook_reg, shook_reg)
    `LPPD_ASSERT_NOW(a_hs_ok_flag, out_valid_reg && (event_reg == EV_HS_OK), shook_reg)

endmodule

>>> hw/rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Parses a byte stream of handshake, text and resize packets into events.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and gives at most one result beat per
// byte, so a stream runs at a sustained one byte per cycle while the result
// port takes every beat. The front parser decodes a byte in the cycle it is
// accepted and queues its command at that edge; the back end pops and
// executes a command once its result beat register is empty or being taken,
// and m_valid comes from that register. A queue of QueueDepth commands
// lets the parser keep taking bytes while the result port is stalled; s_ready
// drops only once that queue is full. Configuration writes are taken every
// cycle on the cfg channel; an index past the three registers is dropped.
module length_prefixed_packet_deframer #(
    parameter int unsigned QueueDepth = lppd_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_event_res,
    output logic [7:0]                     m_text_byte,
    output logic                           m_text_last,
    output logic signed [31:0]             m_cur_width,
    output logic signed [31:0]             m_cur_height,
    output logic                           m_shook_hands
);
    import lppd_pkg::*;

    cmd_t cmd, head_cmd;
    logic cmd_valid, q_full, head_valid, pop;

    lppd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    lppd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lppd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_text_byte   (m_text_byte),
        .m_text_last   (m_text_last),
        .m_cur_width   (m_cur_width),
        .m_cur_height  (m_cur_height),
        .m_shook_hands (m_shook_hands)
    );

endmodule

>>> tb/sv/length_prefixed_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer testbench
// Streams handshake, text, resize and unknown-id packets into the deframer
// byte by byte, predicts each event beat with a local parser model, and
// compares every result beat field by field. Register settings are swept
// between phases, with random gaps on the byte stream and random result stalls.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_tb;

    import lppd_pkg::*;

    localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no beat anywhere
    localparam int unsigned IDLE_SETTLE  = 16;    // let the command queue drain
    localparam int unsigned FINAL_SETTLE = 20;

    // index with no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // parser phases of the local model
    typedef enum logic [2:0] {
        AWAIT_ID,
        HS_VERSION,
        HS_WIDTH,
        HS_HEIGHT,
        TEXT_LENGTH,
        TEXT_BODY,
        RESIZE_WIDTH,
        RESIZE_HEIGHT
    } parse_phase_t;

    typedef struct {
        event_t             ev;
        logic [7:0]         text;
        logic               last;
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic               shook;
    } deframer_event_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_in_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [3:0]           m_event_res;
    logic [7:0]           m_text_byte;
    logic                 m_text_last;
    logic signed [31:0]   m_cur_width;
    logic signed [31:0]   m_cur_height;
    logic                 m_shook_hands;

    // model registers
    logic [31:0]        want_version;
    logic signed [31:0] limit_width;
    logic signed [31:0] limit_height;

    // model parser state
    parse_phase_t       phase;
    logic [1:0]         byte_count;
    logic [31:0]        word_acc;
    logic [31:0]        hold_version;
    logic signed [31:0] hold_width;
    logic [30:0]        text_left;
    logic signed [31:0] term_width;
    logic signed [31:0] term_height;
    logic               shook;

    deframer_event_t pending_events[$];

    int unsigned bytes_sent   = 0;
    int unsigned reg_writes   = 0;
    int unsigned beats_seen   = 0;
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned event_hits[16];
    bit          steady_flow  = 1'b0;

    always #5 aclk = ~aclk;

    length_prefixed_packet_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_text_byte   (m_text_byte),
        .m_text_last   (m_text_last),
        .m_cur_width   (m_cur_width),
        .m_cur_height  (m_cur_height),
        .m_shook_hands (m_shook_hands)
    );

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    task automatic reset_model();
        want_version = RST_ALLOWED_VERSION;
        limit_width  = RST_MAX_WIDTH;
        limit_height = RST_MAX_HEIGHT;
        phase        = AWAIT_ID;
        byte_count   = '0;
        word_acc     = '0;
        hold_version = '0;
        hold_width   = '0;
        text_left    = '0;
        term_width   = '0;
        term_height  = '0;
        shook        = 1'b0;
    endtask

    function automatic bit over_limit(input logic signed [31:0] w,
                                      input logic signed [31:0] h);
        return (w > limit_width) || (h > limit_height);
    endfunction

    task automatic post_event(input event_t ev, input logic [7:0] ch, input logic last);
        deframer_event_t e;
        e.ev     = ev;
        e.text   = ch;
        e.last   = last;
        e.width  = term_width;
        e.height = term_height;
        e.shook  = shook;
        pending_events.push_back(e);
    endtask

    // advance the model by one accepted stream byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [31:0] word;
        // text body bytes bypass word assembly
        if (phase == TEXT_BODY) begin
            text_left = text_left - 31'd1;
            if (text_left == 31'd0) begin
                phase = AWAIT_ID;
                post_event(EV_TEXT, b, 1'b1);
            end else begin
                post_event(EV_TEXT, b, 1'b0);
            end
            return;
        end
        word_acc   = {word_acc[23:0], b};
        byte_count = byte_count + 2'd1;
        if (byte_count != 2'd0)
            return;
        word = word_acc;
        case (phase)
            AWAIT_ID: begin
                if (word == ID_HANDSHAKE)
                    phase = HS_VERSION;
                else if (word == ID_TEXT)
                    phase = TEXT_LENGTH;
                else if (word == ID_RESIZE)
                    phase = RESIZE_WIDTH;
                else
                    post_event(EV_UNKNOWN, 8'd0, 1'b0);
            end
            HS_VERSION: begin
                hold_version = word;
                phase        = HS_WIDTH;
            end
            HS_WIDTH: begin
                hold_width = word;
                phase      = HS_HEIGHT;
            end
            HS_HEIGHT: begin
                phase = AWAIT_ID;
                // version first, then size; a rejected handshake stores nothing
                if (hold_version != want_version) begin
                    post_event(EV_HS_VER, 8'd0, 1'b0);
                end else if (over_limit(hold_width, word)) begin
                    post_event(EV_HS_BIG, 8'd0, 1'b0);
                end else begin
                    term_width  = hold_width;
                    term_height = word;
                    shook       = 1'b1;
                    post_event(EV_HS_OK, 8'd0, 1'b0);
                end
            end
            TEXT_LENGTH: begin
                if (word[31]) begin
                    phase = AWAIT_ID;
                    post_event(EV_NEG_LEN, 8'd0, 1'b0);
                end else if (word == 32'd0) begin
                    phase = AWAIT_ID;
                    post_event(EV_EMPTY, 8'd0, 1'b0);
                end else begin
                    text_left = word[30:0];
                    phase     = TEXT_BODY;
                end
            end
            RESIZE_WIDTH: begin
                hold_width = word;
                phase      = RESIZE_HEIGHT;
            end
            default: begin
                // resize is stored even when over the limits
                phase       = AWAIT_ID;
                term_width  = hold_width;
                term_height = word;
                if (over_limit(term_width, term_height))
                    post_event(EV_RS_BIG, 8'd0, 1'b0);
                else
                    post_event(EV_RS_OK, 8'd0, 1'b0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned draw_wait();
        if (steady_flow)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
    endfunction

    // one stream beat; valid stays high into the next byte when no gap is drawn
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_handshake(input logic [31:0] ver, input logic [31:0] w,
                                  input logic [31:0] h);
        send_word(ID_HANDSHAKE);
        send_word(ver);
        send_word(w);
        send_word(h);
    endtask

    task automatic send_resize(input logic [31:0] w, input logic [31:0] h);
        send_word(ID_RESIZE);
        send_word(w);
        send_word(h);
    endtask

    task automatic send_text(input logic [31:0] len);
        send_word(ID_TEXT);
        send_word(len);
        if (!len[31]) begin
            for (int unsigned n = 0; n < len; n++)
                send_byte(8'($urandom));
        end
    endtask

    // valid is held across the burst and dropped once at the end
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ALLOWED_VERSION: want_version = data;
            REG_MAX_WIDTH:       limit_width  = data;
            REG_MAX_HEIGHT:      limit_height = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [31:0] ver, input logic [31:0] w,
                             input logic [31:0] h);
        write_reg(REG_ALLOWED_VERSION, ver);
        write_reg(REG_MAX_WIDTH, w);
        write_reg(REG_MAX_HEIGHT, h);
        write_reg(REG_NONE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // block idle: every event back, then time for non-result commands to retire
    task automatic wait_idle(input int unsigned settle);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_version();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return want_version ^ 32'd1;
            default: return want_version;
        endcase
    endfunction

    function automatic logic [31:0] pick_size(input logic signed [31:0] limit);
        case ($urandom_range(0, 7))
            0:       return limit;
            1:       return limit + 32'sd1;
            2:       return limit - 32'sd1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return $urandom;
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return {1'b1, 31'($urandom)};
            2:       return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic logic [31:0] pick_unknown_id();
        logic [31:0] id;
        id = $urandom;
        if (id == ID_HANDSHAKE || id == ID_TEXT || id == ID_RESIZE)
            id = ~id;
        return id;
    endfunction

    // Random packet stream driven from the model's phase, so every packet
    // is parsed in full; random words stand in for corrupt fields and junk.
    task automatic stream_random(input int unsigned n_bytes);
        int unsigned first;
        first = bytes_sent;
        while ((bytes_sent - first) < n_bytes || phase != AWAIT_ID) begin
            case (phase)
                AWAIT_ID: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: send_word(ID_HANDSHAKE);
                        3, 4, 5: send_word(ID_TEXT);
                        6, 7:    send_word(ID_RESIZE);
                        default: send_word(pick_unknown_id());
                    endcase
                end
                HS_VERSION:                  send_word(pick_version());
                HS_WIDTH, RESIZE_WIDTH:      send_word(pick_size(limit_width));
                HS_HEIGHT, RESIZE_HEIGHT:    send_word(pick_size(limit_height));
                TEXT_LENGTH:                 send_word(pick_length());
                default:                     send_byte(8'($urandom));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // every packet kind and outcome at reset register values
    task automatic test_directed_packets();
        send_handshake(RST_ALLOWED_VERSION, 32'd80, 32'd24);
        send_handshake(32'd2, 32'd80, 32'd24);
        send_handshake(32'h8000_0000, 32'd80, 32'd24);
        send_handshake(RST_ALLOWED_VERSION, 32'd1025, 32'd24);
        send_handshake(RST_ALLOWED_VERSION, 32'd80, 32'd1025);
        send_handshake(RST_ALLOWED_VERSION, RST_MAX_WIDTH, RST_MAX_HEIGHT);
        send_handshake(RST_ALLOWED_VERSION, -32'sd5, -32'sd7);
        send_handshake(RST_ALLOWED_VERSION, 32'h8000_0000, 32'd0);
        send_text(32'd1);
        // text body carrying the extreme byte values
        send_word(ID_TEXT);
        send_word(32'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_text(32'd0);
        send_text(32'h8000_0000);
        send_text(32'hFFFF_FFFF);
        // body that looks like a resize id must stay text
        send_word(ID_TEXT);
        send_word(32'd4);
        send_word(ID_RESIZE);
        send_resize(32'd640, 32'd480);
        send_resize(32'd2000, 32'd10);
        send_resize(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'd3);
        send_word(32'hFFFF_FFFF);
    endtask

    // register sweep through the extremes and other settings, a random stream under each
    task automatic test_register_extremes();
        wait_idle(IDLE_SETTLE);
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        stream_random(40);
        wait_idle(IDLE_SETTLE);
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        stream_random(40);
        wait_idle(IDLE_SETTLE);
        configure(32'd0, 32'd100, 32'd50);
        steady_flow = 1'b1;
        stream_random(40);
        steady_flow = 1'b0;
        wait_idle(IDLE_SETTLE);
        configure($urandom, $urandom, $urandom);
        stream_random(40);
    endtask

    task automatic test_random_stream();
        wait_idle(IDLE_SETTLE);
        configure(RST_ALLOWED_VERSION, RST_MAX_WIDTH, RST_MAX_HEIGHT);
        stream_random(100);
    endtask

    // ------------------------------------------------------------------
    // Result consumer with random stalls
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        deframer_event_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            event_hits[m_event_res]++;
            if (pending_events.size() == 0) begin
                $error("result beat with no event expected, event_res %0d", m_event_res);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", want.ev, m_event_res);
                check_field("text_byte", want.text, m_text_byte);
                check_field("text_last", want.last, m_text_last);
                check_field("cur_width", want.width, m_cur_width);
                check_field("cur_height", want.height, m_cur_height);
                check_field("shook_hands", want.shook, m_shook_hands);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat on any channel for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d events outstanding",
                     STALL_LIMIT, pending_events.size());
            $display("length_prefixed_packet_deframer_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        string mix;
        reset_model();
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_in_byte <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_packets();
        test_register_extremes();
        test_random_stream();

        wait_idle(FINAL_SETTLE);

        mix = "";
        for (int e = EV_HS_OK; e <= EV_NEG_LEN; e++)
            mix = {mix, $sformatf(" %0d", event_hits[e])};
        $display("run covered %0d stream bytes, %0d register writes, %0d result beats",
                 bytes_sent, reg_writes, beats_seen);
        $display("beats per event code 0..8:%s", mix);
        if (error_count == 0)
            $display("length_prefixed_packet_deframer_tb OK");
        else
            $display("length_prefixed_packet_deframer_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lppd_pkg.sv
hw/rtl/lppd_front.sv
hw/rtl/lppd_queue.sv
hw/rtl/lppd_back.sv
hw/rtl/length_prefixed_packet_deframer.sv
tb/sv/length_prefixed_packet_deframer_tb.sv
